// ===== src/grd_pkg.sv =====
// shared types, widths and register codes for the gamepad radial deadzone shaper
`default_nettype none
package grd_pkg;

    localparam int AXIS_W    = 16;
    localparam int STICKS    = 2;
    localparam int AXES      = 4;
    localparam int OUT_LANES = 5;
    localparam int DZ_W      = 15;
    localparam int SQ_W      = 32;
    localparam int ROOT_W    = 24;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int REM_W     = ROOT_W + 4;
    localparam int QUO_W     = 17;
    localparam int NDIV_W    = DZ_W;
    localparam int ODIV_W    = ROOT_W;
    localparam int AXIS_FULL = 32767;

    localparam logic [ROOT_W-1:0] CLIP_ROOT = ROOT_W'(AXIS_FULL * 256);

    typedef enum logic [1:0] {
        CFG_SOURCE_MODE,
        CFG_LEFT_DZ,
        CFG_RIGHT_DZ,
        CFG_TRIG_THR
    } t_cfg_idx;

    typedef struct packed {
        logic [AXIS_W-1:0] left_x;
        logic [AXIS_W-1:0] left_y;
        logic [AXIS_W-1:0] right_x;
        logic [AXIS_W-1:0] right_y;
        logic [AXIS_W-1:0] trigger_neg;
        logic [AXIS_W-1:0] trigger_pos;
    } t_in;

    typedef struct packed {
        logic signed [AXIS_W-1:0] left_x_out;
        logic signed [AXIS_W-1:0] left_y_out;
        logic signed [AXIS_W-1:0] right_x_out;
        logic signed [AXIS_W-1:0] right_y_out;
        logic signed [AXIS_W-1:0] trigger_out;
    } t_out;

    // per-item flags and magnitudes that ride along the root chain
    typedef struct packed {
        logic [STICKS-1:0]             zero;
        logic [AXES-1:0]               neg;
        logic [AXES-1:0][AXIS_W-1:0]   mag;
        logic                          trig_neg;
        logic                          trig_zero;
        logic [AXIS_W-1:0]             trig_mag;
        logic [AXIS_W-1:0]             trig_den;
    } t_side_a;

    typedef struct packed {
        t_side_a                       a;
        logic [STICKS-1:0][ROOT_W-1:0] root;
    } t_side_b;

    typedef struct packed {
        logic [STICKS-1:0] zero;
        logic [AXES-1:0]   neg;
        logic              trig_neg;
        logic              trig_zero;
    } t_side_c;

endpackage
`default_nettype wire

// ===== src/grd_root_cell.sv =====
// one digit step of the square root chain, one bit of root per cell
`default_nettype none
module grd_root_cell #(
    parameter int LANES = grd_pkg::STICKS,
    parameter int SW    = 1
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_take,
    input  wire logic                                   i_adv,
    output logic                                        o_valid,
    input  wire logic [LANES-1:0][grd_pkg::REM_W-1:0]   i_rem,
    input  wire logic [LANES-1:0][grd_pkg::ROOT_W-1:0]  i_root,
    input  wire logic [LANES-1:0][grd_pkg::RAD_W-1:0]   i_bits,
    input  wire logic [SW-1:0]                          i_side,
    output logic [LANES-1:0][grd_pkg::REM_W-1:0]        o_rem,
    output logic [LANES-1:0][grd_pkg::ROOT_W-1:0]       o_root,
    output logic [LANES-1:0][grd_pkg::RAD_W-1:0]        o_bits,
    output logic [SW-1:0]                               o_side
);

    logic                                      r_valid;
    logic [LANES-1:0][grd_pkg::REM_W-1:0]      r_rem,  n_rem;
    logic [LANES-1:0][grd_pkg::ROOT_W-1:0]     r_root, n_root;
    logic [LANES-1:0][grd_pkg::RAD_W-1:0]      r_bits, n_bits;
    logic [SW-1:0]                             r_side;

    assign o_take = !r_valid || i_adv;

    always_comb begin
        logic [grd_pkg::REM_W-1:0] ext;
        logic [grd_pkg::REM_W-1:0] trial;
        logic                      ge;
        for (int l = 0; l < LANES; l++) begin
            ext   = {i_rem[l][grd_pkg::REM_W-3:0], i_bits[l][grd_pkg::RAD_W-1 -: 2]};
            trial = {{(grd_pkg::REM_W-grd_pkg::ROOT_W-2){1'b0}}, i_root[l], 2'b01};
            ge    = (ext >= trial);
            n_rem[l]  = ge ? (ext - trial) : ext;
            n_root[l] = {i_root[l][grd_pkg::ROOT_W-2:0], ge};
            n_bits[l] = {i_bits[l][grd_pkg::RAD_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_bits <= n_bits;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_bits  = r_bits;
    assign o_side  = r_side;

endmodule
`default_nettype wire

// ===== src/grd_div_cell.sv =====
// one restoring division step, one quotient bit per cell
`default_nettype none
module grd_div_cell #(
    parameter int LANES = grd_pkg::STICKS,
    parameter int DVW   = grd_pkg::NDIV_W,
    parameter int QW    = grd_pkg::QUO_W,
    parameter int SW    = 1
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_take,
    input  wire logic                      i_adv,
    output logic                           o_valid,
    input  wire logic [LANES-1:0][DVW-1:0] i_rem,
    input  wire logic [LANES-1:0][QW-1:0]  i_acc,
    input  wire logic [LANES-1:0][DVW-1:0] i_div,
    input  wire logic [SW-1:0]             i_side,
    output logic [LANES-1:0][DVW-1:0]      o_rem,
    output logic [LANES-1:0][QW-1:0]       o_acc,
    output logic [LANES-1:0][DVW-1:0]      o_div,
    output logic [SW-1:0]                  o_side
);

    logic                         r_valid;
    logic [LANES-1:0][DVW-1:0]    r_rem, n_rem;
    logic [LANES-1:0][QW-1:0]     r_acc, n_acc;
    logic [LANES-1:0][DVW-1:0]    r_div;
    logic [SW-1:0]                r_side;

    assign o_take = !r_valid || i_adv;

    // acc holds the dividend bits still to come and collects quotient bits behind them
    always_comb begin
        logic [DVW:0] ext;
        logic [DVW:0] dsr;
        logic         ge;
        for (int l = 0; l < LANES; l++) begin
            ext = {i_rem[l], i_acc[l][QW-1]};
            dsr = {1'b0, i_div[l]};
            ge  = (ext >= dsr);
            n_rem[l] = ge ? DVW'(ext - dsr) : ext[DVW-1:0];
            n_acc[l] = {i_acc[l][QW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_rem  <= n_rem;
            r_acc  <= n_acc;
            r_div  <= i_div;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_acc   = r_acc;
    assign o_div   = r_div;
    assign o_side  = r_side;

endmodule
`default_nettype wire

// ===== src/gamepad_radial_deadzone_shaper.sv =====
// top level: radial deadzone and quadratic response for two sticks, trigger difference
// Use: one poll sample enters on the input channel (i_in_valid / o_in_stall) as a
// t_in item and one shaped t_out item leaves on the output channel
// (o_out_valid / i_out_stall). Items are taken at an edge with valid high and
// stall low. Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data
// while no item is in flight.
// The chain has one decode and square stage, 24 root cells (one bit of
// the magnitude each), 17 cells for the response divide, two multiply stages,
// 17 cells for the direction divide and the output register.
// Throughput is one item per cycle while the receiver does not stall.
// Each cell advances when it is empty or its neighbor takes, so when the receiver
// stalls the chain keeps filling its empty cells and o_in_stall rises only once
// the front stage is held by a full chain.
// Synchronous reset empties all cells and the output register and loads the
// register defaults (mode 0, deadzones 7849 and 8689, threshold 30).
`default_nettype none
module gamepad_radial_deadzone_shaper (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire grd_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output grd_pkg::t_out      o_out_data,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_idx,
    input  wire logic [15:0]   i_cfg_data
);

    localparam int RW  = grd_pkg::ROOT_W;
    localparam int QW  = grd_pkg::QUO_W;
    localparam int SWA = $bits(grd_pkg::t_side_a);
    localparam int SWB = $bits(grd_pkg::t_side_b);
    localparam int SWC = $bits(grd_pkg::t_side_c);

    // configuration
    logic                      r_mode;
    logic [grd_pkg::DZ_W-1:0]  r_ldz;
    logic [grd_pkg::DZ_W-1:0]  r_rdz;
    logic [15:0]               r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_ldz  <= 15'd7849;
            r_rdz  <= 15'd8689;
            r_thr  <= 16'd30;
        end else if (i_cfg_we) begin
            unique case (grd_pkg::t_cfg_idx'(i_cfg_idx))
                grd_pkg::CFG_SOURCE_MODE: r_mode <= i_cfg_data[0];
                grd_pkg::CFG_LEFT_DZ:     r_ldz  <= i_cfg_data[14:0];
                grd_pkg::CFG_RIGHT_DZ:    r_rdz  <= i_cfg_data[14:0];
                grd_pkg::CFG_TRIG_THR:    r_thr  <= i_cfg_data;
                default:                  r_mode <= r_mode;
            endcase
        end
    end

    logic [grd_pkg::STICKS-1:0][grd_pkg::DZ_W-1:0] dz;
    assign dz[0] = r_ldz;
    assign dz[1] = r_mode ? r_ldz : r_rdz;

    // chain links
    logic [RW:0]                                        root_v;
    logic [RW:0]                                        root_take;
    logic [grd_pkg::STICKS-1:0][grd_pkg::REM_W-1:0]     root_rem  [0:RW];
    logic [grd_pkg::STICKS-1:0][RW-1:0]                 root_root [0:RW];
    logic [grd_pkg::STICKS-1:0][grd_pkg::RAD_W-1:0]     root_bits [0:RW];
    grd_pkg::t_side_a                                   root_side [0:RW];

    logic [QW:0]                                        d1_v;
    logic [QW:0]                                        d1_take;
    logic [grd_pkg::STICKS-1:0][grd_pkg::NDIV_W-1:0]    d1_rem  [0:QW];
    logic [grd_pkg::STICKS-1:0][QW-1:0]                 d1_acc  [0:QW];
    logic [grd_pkg::STICKS-1:0][grd_pkg::NDIV_W-1:0]    d1_div  [0:QW];
    grd_pkg::t_side_b                                   d1_side [0:QW];

    logic [QW:0]                                        d2_v;
    logic [QW:0]                                        d2_take;
    logic [grd_pkg::OUT_LANES-1:0][grd_pkg::ODIV_W-1:0] d2_rem  [0:QW];
    logic [grd_pkg::OUT_LANES-1:0][QW-1:0]              d2_acc  [0:QW];
    logic [grd_pkg::OUT_LANES-1:0][grd_pkg::ODIV_W-1:0] d2_div  [0:QW];
    grd_pkg::t_side_c                                   d2_side [0:QW];

    // front stage: decode, absolute values, squares, trigger deadzone
    logic                                             r_f_valid;
    logic                                             f_take;
    logic [grd_pkg::AXES-1:0][grd_pkg::SQ_W-1:0]      r_f_sq,  n_f_sq;
    logic [grd_pkg::STICKS-1:0][2*grd_pkg::DZ_W-1:0]  r_f_dz2, n_f_dz2;
    grd_pkg::t_side_a                                 r_f_side, n_f_side;

    assign f_take     = !r_f_valid || root_take[0];
    assign o_in_stall = !f_take;

    always_comb begin
        logic [grd_pkg::AXES-1:0][15:0] raw;
        logic [16:0] s;
        logic [16:0] av;
        logic [15:0] tn;
        logic [15:0] tp;
        logic [16:0] d;
        logic [16:0] dabs;
        logic [14:0] h;
        logic [15:0] fs;
        raw[0] = i_in_data.left_x;
        raw[1] = i_in_data.left_y;
        raw[2] = i_in_data.right_x;
        raw[3] = i_in_data.right_y;
        n_f_side = '0;
        for (int i = 0; i < grd_pkg::AXES; i++) begin
            s  = r_mode ? ({1'b0, raw[i]} - 17'd32767) : {raw[i][15], raw[i]};
            av = s[16] ? (17'd0 - s) : s;
            n_f_side.neg[i] = s[16];
            n_f_side.mag[i] = av[15:0];
            n_f_sq[i] = {16'b0, av[15:0]} * {16'b0, av[15:0]};
        end
        for (int k = 0; k < grd_pkg::STICKS; k++) begin
            n_f_dz2[k] = {15'b0, dz[k]} * {15'b0, dz[k]};
        end
        tn   = r_mode ? i_in_data.trigger_neg : {8'b0, i_in_data.trigger_neg[7:0]};
        tp   = r_mode ? i_in_data.trigger_pos : {8'b0, i_in_data.trigger_pos[7:0]};
        d    = {1'b0, tp} - {1'b0, tn};
        dabs = d[16] ? (17'd0 - d) : d;
        h    = r_thr[15:1];
        fs   = r_mode ? 16'hFFFF : 16'd255;
        n_f_side.trig_neg  = d[16];
        n_f_side.trig_mag  = (dabs >= {2'b0, h}) ? 16'(dabs - {2'b0, h}) : 16'd0;
        // full scale at or below half the threshold gives no trigger output
        n_f_side.trig_zero = !r_mode && (h >= 15'd255);
        n_f_side.trig_den  = fs - {1'b0, h};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (f_take) begin
            r_f_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_take && i_in_valid) begin
            r_f_sq   <= n_f_sq;
            r_f_dz2  <= n_f_dz2;
            r_f_side <= n_f_side;
        end
    end

    // root chain input: magnitude squared and the exact deadzone test
    always_comb begin
        logic [grd_pkg::SQ_W-1:0] m2;
        root_side[0] = r_f_side;
        for (int k = 0; k < grd_pkg::STICKS; k++) begin
            m2 = r_f_sq[2*k] + r_f_sq[2*k+1];
            root_side[0].zero[k] = (dz[k] == 15'h7FFF) || (m2 <= {2'b0, r_f_dz2[k]});
            root_bits[0][k] = {m2, 16'b0};
            root_rem[0][k]  = '0;
            root_root[0][k] = '0;
        end
    end
    assign root_v[0] = r_f_valid;
    assign root_take[RW] = d1_take[0];

    for (genvar g = 0; g < RW; g++) begin : g_root
        logic [SWA-1:0] side_out;
        grd_root_cell #(
            .LANES(grd_pkg::STICKS),
            .SW   (SWA)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(root_v[g]),
            .o_take (root_take[g]),
            .i_adv  (root_take[g+1]),
            .o_valid(root_v[g+1]),
            .i_rem  (root_rem[g]),
            .i_root (root_root[g]),
            .i_bits (root_bits[g]),
            .i_side (root_side[g]),
            .o_rem  (root_rem[g+1]),
            .o_root (root_root[g+1]),
            .o_bits (root_bits[g+1]),
            .o_side (side_out)
        );
        assign root_side[g+1] = side_out;
    end

    // response divide input: clip, remove deadzone, scale by 256
    always_comb begin
        logic [RW-1:0] r;
        logic [RW-1:0] c;
        logic [RW-1:0] lo;
        logic [RW-1:0] num;
        logic [grd_pkg::NDIV_W+QW-1:0] dvd;
        d1_side[0].a = root_side[RW];
        for (int k = 0; k < grd_pkg::STICKS; k++) begin
            r   = root_root[RW][k];
            c   = (r > grd_pkg::CLIP_ROOT) ? grd_pkg::CLIP_ROOT : r;
            lo  = {1'b0, dz[k], 8'b0};
            num = (c > lo) ? (c - lo) : '0;
            dvd = {num, 8'b0};
            d1_side[0].root[k] = r;
            d1_rem[0][k] = dvd[grd_pkg::NDIV_W+QW-1:QW];
            d1_acc[0][k] = dvd[QW-1:0];
            d1_div[0][k] = 15'h7FFF - dz[k];
        end
    end
    assign d1_v[0] = root_v[RW];

    for (genvar g = 0; g < QW; g++) begin : g_div1
        logic [SWB-1:0] side_out;
        grd_div_cell #(
            .LANES(grd_pkg::STICKS),
            .DVW  (grd_pkg::NDIV_W),
            .QW   (QW),
            .SW   (SWB)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(d1_v[g]),
            .o_take (d1_take[g]),
            .i_adv  (d1_take[g+1]),
            .o_valid(d1_v[g+1]),
            .i_rem  (d1_rem[g]),
            .i_acc  (d1_acc[g]),
            .i_div  (d1_div[g]),
            .i_side (d1_side[g]),
            .o_rem  (d1_rem[g+1]),
            .o_acc  (d1_acc[g+1]),
            .o_div  (d1_div[g+1]),
            .o_side (side_out)
        );
        assign d1_side[g+1] = side_out;
    end

    // square of the response
    logic                                 r_m1_valid;
    logic                                 m1_take;
    logic                                 m2_take;
    logic [grd_pkg::STICKS-1:0][QW-1:0]   r_m1_n2, n_m1_n2;
    grd_pkg::t_side_b                     r_m1_side;

    assign m1_take = !r_m1_valid || m2_take;
    assign d1_take[QW] = m1_take;

    always_comb begin
        logic [2*QW-1:0] p;
        for (int k = 0; k < grd_pkg::STICKS; k++) begin
            p = {{QW{1'b0}}, d1_acc[QW][k]} * {{QW{1'b0}}, d1_acc[QW][k]};
            n_m1_n2[k] = p[QW+15:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid <= 1'b0;
        end else if (m1_take) begin
            r_m1_valid <= d1_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (m1_take && d1_v[QW]) begin
            r_m1_n2   <= n_m1_n2;
            r_m1_side <= d1_side[QW];
        end
    end

    // axis magnitude times squared response
    logic                                        r_m2_valid;
    logic [grd_pkg::AXES-1:0][grd_pkg::AXIS_W+QW-1:0] r_m2_prod, n_m2_prod;
    grd_pkg::t_side_b                            r_m2_side;

    assign m2_take = !r_m2_valid || d2_take[0];

    always_comb begin
        for (int i = 0; i < grd_pkg::AXES; i++) begin
            n_m2_prod[i] = {{QW{1'b0}}, r_m1_side.a.mag[i]}
                         * {{grd_pkg::AXIS_W{1'b0}}, r_m1_n2[i/2]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_valid <= 1'b0;
        end else if (m2_take) begin
            r_m2_valid <= r_m1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m2_take && r_m1_valid) begin
            r_m2_prod <= n_m2_prod;
            r_m2_side <= r_m1_side;
        end
    end

    // direction divide input: four axes over the unclipped magnitude, trigger over its span
    always_comb begin
        logic [grd_pkg::ODIV_W+QW-1:0] dvd;
        for (int i = 0; i < grd_pkg::AXES; i++) begin
            dvd = {2'b0, r_m2_prod[i], 6'b0};
            d2_rem[0][i] = dvd[grd_pkg::ODIV_W+QW-1:QW];
            d2_acc[0][i] = dvd[QW-1:0];
            d2_div[0][i] = r_m2_side.root[i/2];
        end
        dvd = {11'b0, r_m2_side.a.trig_mag, 14'b0};
        d2_rem[0][grd_pkg::AXES] = dvd[grd_pkg::ODIV_W+QW-1:QW];
        d2_acc[0][grd_pkg::AXES] = dvd[QW-1:0];
        d2_div[0][grd_pkg::AXES] = {8'b0, r_m2_side.a.trig_den};
        d2_side[0].zero      = r_m2_side.a.zero;
        d2_side[0].neg       = r_m2_side.a.neg;
        d2_side[0].trig_neg  = r_m2_side.a.trig_neg;
        d2_side[0].trig_zero = r_m2_side.a.trig_zero;
    end
    assign d2_v[0] = r_m2_valid;

    for (genvar g = 0; g < QW; g++) begin : g_div2
        logic [SWC-1:0] side_out;
        grd_div_cell #(
            .LANES(grd_pkg::OUT_LANES),
            .DVW  (grd_pkg::ODIV_W),
            .QW   (QW),
            .SW   (SWC)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(d2_v[g]),
            .o_take (d2_take[g]),
            .i_adv  (d2_take[g+1]),
            .o_valid(d2_v[g+1]),
            .i_rem  (d2_rem[g]),
            .i_acc  (d2_acc[g]),
            .i_div  (d2_div[g]),
            .i_side (d2_side[g]),
            .o_rem  (d2_rem[g+1]),
            .o_acc  (d2_acc[g+1]),
            .o_div  (d2_div[g+1]),
            .o_side (side_out)
        );
        assign d2_side[g+1] = side_out;
    end

    // output register: signs, per-mode axis flips, zeroing
    logic           r_o_valid;
    logic           o_take;
    grd_pkg::t_out  r_o_data, n_o_data;

    assign o_take = !r_o_valid || !i_out_stall;
    assign d2_take[QW] = o_take;

    always_comb begin
        logic [grd_pkg::AXES-1:0][15:0] v;
        logic [grd_pkg::AXES-1:0]       flip;
        logic [15:0]                    q;
        logic [15:0]                    t;
        flip = {r_mode, 1'b1, !r_mode, 1'b0};
        for (int i = 0; i < grd_pkg::AXES; i++) begin
            q = d2_acc[QW][i][15:0];
            if (d2_side[QW].zero[i/2]) begin
                v[i] = '0;
            end else begin
                v[i] = (d2_side[QW].neg[i] ^ flip[i]) ? (16'd0 - q) : q;
            end
        end
        q = d2_acc[QW][grd_pkg::AXES][15:0];
        if (d2_side[QW].trig_zero) begin
            t = '0;
        end else begin
            t = d2_side[QW].trig_neg ? (16'd0 - q) : q;
        end
        n_o_data.left_x_out  = v[0];
        n_o_data.left_y_out  = v[1];
        n_o_data.right_x_out = v[2];
        n_o_data.right_y_out = v[3];
        n_o_data.trigger_out = t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_take) begin
            r_o_valid <= d2_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && d2_v[QW]) begin
            r_o_data <= n_o_data;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

    // the input side only stalls while the front stage holds an item
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_f_valid)
        else $error("input stalled with an empty front stage");

    a_stick_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_data.left_x_out  <= 16'sd16384) && (o_out_data.left_x_out  >= -16'sd16384) &&
            (o_out_data.left_y_out  <= 16'sd16384) && (o_out_data.left_y_out  >= -16'sd16384) &&
            (o_out_data.right_x_out <= 16'sd16384) && (o_out_data.right_x_out >= -16'sd16384) &&
            (o_out_data.right_y_out <= 16'sd16384) && (o_out_data.right_y_out >= -16'sd16384))
        else $error("stick output beyond unit range");

    a_trig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_data.trigger_out <= 16'sd16384) && (o_out_data.trigger_out >= -16'sd16384))
        else $error("trigger output beyond unit range");

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// self-checking testbench for the gamepad radial deadzone shaper
`timescale 1ns / 100ps
`default_nettype none
module testbench;

    typedef struct {
        grd_pkg::t_in  stim;
        bit            typed;
        grd_pkg::t_out want;
    } t_row;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    grd_pkg::t_in      in_data = '0;
    logic              out_stall = 1'b0;
    logic              cfg_we = 1'b0;
    grd_pkg::t_cfg_idx cfg_idx = grd_pkg::CFG_SOURCE_MODE;
    logic [15:0]       cfg_data = '0;
    logic              in_stall;
    logic              out_valid;
    grd_pkg::t_out     out_data;

    // mirror of the block's registers
    bit          cur_mode;
    logic [14:0] cur_ldz;
    logic [14:0] cur_rdz;
    logic [15:0] cur_thr;

    grd_pkg::t_out shaped_q[$];
    int   n_sent;
    int   n_checked;
    int   n_bad;
    bit   calm;
    bit   hold_req;

    gamepad_radial_deadzone_shaper uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'h4000_0000_0000_0000;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic int axis_value(logic [15:0] raw);
        if (cur_mode) return int'(raw) - grd_pkg::AXIS_FULL;
        return int'($signed(raw));
    endfunction

    // radial deadzone plus squared response for one stick
    function automatic void shape_stick(int x, int y, int dz, output int ox, output int oy);
        longint unsigned ax, ay, m2, r, c, lo, num, n, n2;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        m2 = ax * ax + ay * ay;
        ox = 0;
        oy = 0;
        if (dz >= grd_pkg::AXIS_FULL || m2 <= longint'(dz) * dz) return;
        r = int_root(m2 << 16);
        c = (r > grd_pkg::AXIS_FULL * 256) ? grd_pkg::AXIS_FULL * 256 : r;
        lo = dz * 256;
        num = (c > lo) ? c - lo : 0;
        n = num * 256 / (grd_pkg::AXIS_FULL - dz);
        n2 = (n * n) >> 16;
        ox = int'(ax * n2 * 64 / r);
        oy = int'(ay * n2 * 64 / r);
        if (x < 0) ox = -ox;
        if (y < 0) oy = -oy;
    endfunction

    function automatic grd_pkg::t_out shape_sample(grd_pkg::t_in s);
        grd_pkg::t_out o;
        int lx, ly, rx, ry, neg, pos, d, h, fs, den;
        longint p, aq;
        shape_stick(axis_value(s.left_x), axis_value(s.left_y), cur_ldz, lx, ly);
        shape_stick(axis_value(s.right_x), axis_value(s.right_y),
                    cur_mode ? cur_ldz : cur_rdz, rx, ry);
        o.left_x_out  = 16'(lx);
        o.left_y_out  = 16'(cur_mode ? ly : -ly);
        o.right_x_out = 16'(-rx);
        o.right_y_out = 16'(cur_mode ? -ry : ry);
        neg = cur_mode ? int'(s.trigger_neg) : int'(s.trigger_neg[7:0]);
        pos = cur_mode ? int'(s.trigger_pos) : int'(s.trigger_pos[7:0]);
        fs  = cur_mode ? 65535 : 255;
        h   = int'(cur_thr >> 1);
        d   = pos - neg;
        if (d < h && d > -h) d = 0;
        else if (d < 0) d += h;
        else d -= h;
        den = fs - h;
        if (den <= 0) begin
            o.trigger_out = '0;
        end else begin
            p  = longint'(d) * 16384;
            aq = ((p < 0) ? -p : p) / den;
            o.trigger_out = 16'((p < 0) ? -aq : aq);
        end
        return o;
    endfunction

    task automatic write_reg(grd_pkg::t_cfg_idx idx, logic [15:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            grd_pkg::CFG_SOURCE_MODE: cur_mode = val[0];
            grd_pkg::CFG_LEFT_DZ:     cur_ldz = val[14:0];
            grd_pkg::CFG_RIGHT_DZ:    cur_rdz = val[14:0];
            grd_pkg::CFG_TRIG_THR:    cur_thr = val;
        endcase
    endtask

    // block must be empty before registers change
    task automatic drain();
        in_valid <= 1'b0;
        while (shaped_q.size() != 0) @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    task automatic set_regs(bit mode, int ldz, int rdz, int thr);
        drain();
        write_reg(grd_pkg::CFG_SOURCE_MODE, 16'(mode));
        write_reg(grd_pkg::CFG_LEFT_DZ, 16'(ldz));
        write_reg(grd_pkg::CFG_RIGHT_DZ, 16'(rdz));
        write_reg(grd_pkg::CFG_TRIG_THR, 16'(thr));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_item(grd_pkg::t_in s, bit typed, grd_pkg::t_out want);
        if (!calm && $urandom_range(99) < 12) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        do @(posedge clk); while (in_stall);
        shaped_q.push_back(typed ? want : shape_sample(s));
        n_sent++;
    endtask

    // axis values biased toward the deadzone ring and the rails
    function automatic logic [15:0] pick_axis(int dz);
        int v;
        case ($urandom_range(9))
            0, 1: v = $urandom_range(3) == 0 ? -32768 : 32767;
            2:    v = 0;
            3, 4: v = ($urandom_range(1) ? dz : -dz) + int'($urandom_range(8)) - 4;
            5:    v = int'($urandom_range(2 * dz + 2)) - dz - 1;
            default: return 16'($urandom);
        endcase
        if (cur_mode) begin
            if (v < -32767) v = -32767;
            return 16'(v + grd_pkg::AXIS_FULL);
        end
        return 16'(v);
    endfunction

    function automatic logic [15:0] pick_trigger();
        int fs;
        fs = cur_mode ? 65535 : 255;
        case ($urandom_range(5))
            0:       return 16'($urandom_range(1) ? fs : 0);
            1:       return 16'(int'(cur_thr >> 1) + $urandom_range(4));
            2:       return 16'($urandom_range(fs));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_items(int count);
        grd_pkg::t_in s;
        int  rdz;
        rdz = cur_mode ? cur_ldz : cur_rdz;
        repeat (count) begin
            s.left_x      = pick_axis(cur_ldz);
            s.left_y      = pick_axis(cur_ldz);
            s.right_x     = pick_axis(rdz);
            s.right_y     = pick_axis(rdz);
            s.trigger_neg = pick_trigger();
            s.trigger_pos = pick_trigger();
            send_item(s, 1'b0, '0);
        end
    endtask

    // receiver stalls, with one long hold-off on request
    always begin
        @(posedge clk);
        if (hold_req) begin
            out_stall <= 1'b1;
            repeat (300) @(posedge clk);
            hold_req = 1'b0;
        end
        out_stall <= !calm && ($urandom_range(99) < 12);
    end

    always @(posedge clk) begin
        grd_pkg::t_out want;
        logic [4:0][15:0] w, g;
        string lane_name[5];
        if (rst_n && out_valid && !out_stall) begin
            lane_name = '{"trigger_out", "right_y_out", "right_x_out",
                          "left_y_out", "left_x_out"};
            if (shaped_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected item %h", out_data);
            end else begin
                want = shaped_q.pop_front();
                w = want;
                g = out_data;
                for (int i = 0; i < 5; i++) begin
                    if (w[i] !== g[i]) begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display("item %0d %s: expected %0d got %0d", n_checked,
                                     lane_name[i], $signed(w[i]), $signed(g[i]));
                    end
                end
                n_checked++;
            end
        end
    end

    initial begin
        #30ms;
        $display("[gamepad_radial_deadzone_shaper] ERROR");
        $finish;
    end

    initial begin
        t_row rows[$];
        rows = '{
            '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1,
              '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}},
            '{'{16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1,
              '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0}},
            '{'{16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1,
              '{16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd0}},
            '{'{16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000}, 1,
              '{16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0}},
            '{'{16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000}, 1,
              '{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0}},
            '{'{16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h00FF}, 1,
              '{-16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384}},
            '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h00FF, 16'h0000}, 1,
              '{16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd16384}},
            // only the low byte of a trigger counts in signed mode
            '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF}, 1,
              '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}},
            '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFF00, 16'h01FF}, 1,
              '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384}},
            // on the deadzone ring the stick stays zero
            '{'{16'd7849, 16'h0000, 16'd8689, 16'h0000, 16'h0000, 16'h0000}, 1,
              '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}},
            '{'{16'd7850, 16'h0000, 16'd8690, 16'h0000, 16'd10, 16'd30}, 0, '0},
            '{'{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'd0, 16'd15}, 0, '0},
            '{'{16'hFFFF, 16'h8001, 16'h1234, 16'hEDCB, 16'd16, 16'd0}, 0, '0},
            '{'{16'h5555, 16'hAAAA, 16'h3000, 16'h3000, 16'h00AA, 16'h0055}, 0, '0},
            '{'{16'hC000, 16'h4000, 16'h2000, 16'hE000, 16'd100, 16'd200}, 0, '0}
        };
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        cur_mode = 1'b0;
        cur_ldz  = 15'd7849;
        cur_rdz  = 15'd8689;
        cur_thr  = 16'd30;
        @(posedge clk);
        foreach (rows[i]) send_item(rows[i].stim, rows[i].typed, rows[i].want);

        // offset-binary mode, then signed mode: full-scale deadzones and thresholds from 0 to 65535
        set_regs(1'b1, 7849, 0, 6553);
        send_item('{16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h7FFF, 16'h0000, 16'hFFFF}, 0, '0);
        send_item('{16'h0000, 16'hFFFE, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000}, 0, '0);
        set_regs(1'b1, 32767, 0, 65535);
        send_item('{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF}, 1,
                  '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384});
        set_regs(1'b0, 0, 32767, 0);
        send_item('{16'h0001, 16'h0000, 16'h7FFF, 16'h7FFF, 16'd1, 16'd0}, 0, '0);

        set_regs(1'b0, 7849, 8689, 30);
        random_items(180);
        set_regs(1'b1, 7849, 8689, 6553);
        random_items(180);
        calm = 1'b1;
        set_regs(1'b0, 0, 0, 0);
        random_items(180);
        calm = 1'b0;
        set_regs(1'b1, 0, 32766, 65534);
        hold_req = 1'b1;
        random_items(180);
        set_regs(1'b0, 32766, 32767, 511);
        random_items(180);
        set_regs(1'b1, 32767, 100, 1);
        random_items(180);
        set_regs(1'b0, $urandom_range(32767), $urandom_range(32767), $urandom_range(600));
        random_items(180);
        set_regs(1'b1, $urandom_range(32767), $urandom_range(32767), $urandom);
        random_items(180);

        drain();
        $display("%0d samples sent over a dozen register settings in both source modes,",
                 n_sent);
        $display("%0d results checked, %0d field mismatches", n_checked, n_bad);
        if (n_bad == 0 && shaped_q.size() == 0)
            $display("[gamepad_radial_deadzone_shaper] OK");
        else
            $display("[gamepad_radial_deadzone_shaper] ERROR");
        $finish;
    end
endmodule
`default_nettype wire
